FILE: design/stride_share_scheduler_defines.svh
// Assertion macros for the stride share scheduler.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef STRIDE_SHARE_SCHEDULER_DEFINES_SVH
`define STRIDE_SHARE_SCHEDULER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ssch_pkg.sv
// Shared types and constants of the stride share scheduler.
// No dependencies; imported by every module of the block.
package ssch_pkg;

  localparam int unsigned PID_W            = 16;
  localparam int unsigned PASS_W           = 64;
  localparam int unsigned STRIDE_W         = 16;
  localparam int unsigned SHARE_W          = 7;
  localparam int unsigned DIV_W            = 16;
  localparam int unsigned TABLE_DEPTH_DEF  = 16;

  localparam logic [SHARE_W-1:0]  PERCENT_MAX        = 7'd100;
  localparam logic [SHARE_W-1:0]  TOTAL_SHARE_RST    = 7'd100;
  localparam logic [STRIDE_W-1:0] STRIDE_SCALE_RST   = 16'd10000;

  localparam logic CFG_TOTAL_SHARE  = 1'b0;
  localparam logic CFG_STRIDE_SCALE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_END     = 2'd1,
    OP_REQUEST = 2'd2,
    OP_PICK    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY,
    ST_W_REQ,
    ST_REB,
    ST_W_SHR,
    ST_W_STR,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // Entry word of the id/pass memory.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PASS_W-1:0] pass;
  } entry_a_t;

  // Entry word of the stride/share memory.
  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [SHARE_W-1:0]  share;
  } entry_b_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: design/stride_share_scheduler.sv
// Channel   | Dir | Fields (tdata, low bit up)
// s_axis    | in  | op[1:0], proc_id[17:2], percent[24:18], zero pad to 32
// m_axis    | out | status[0], chosen_pid[16:1], zero pad to 24
// cfg       | in  | index 0 total_share, index 1 stride_scale
//
// One transaction at a time. Every operation scans the table through the memory read
// port; a pick or any failed operation then goes straight to its result. A successful start,
// end or request adds a rebalance: a write sweep over the table and up to two serial
// divisions (three for a request). Reset clears the valid and reservation flops and
// counters at once; no clearing pass. A held result does not stop the next transaction
// from being accepted; it completes once the output register is free.
`include "stride_share_scheduler_defines.svh"

module stride_share_scheduler #(
  parameter int unsigned TABLE_DEPTH = ssch_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // op, proc_id, percent
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // status, chosen_pid
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import ssch_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [PID_W-1:0]      pid_q, pid_d;
  logic [SHARE_W-1:0]    pct_q, pct_d;
  logic [IW-1:0]         scan_cnt_q, scan_cnt_d;
  logic                  chk_v_q, chk_v_d;
  logic [IW-1:0]         chk_idx_q, chk_idx_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         hit_idx_q, hit_idx_d;
  logic [PID_W-1:0]      hit_pid_q, hit_pid_d;
  logic [PASS_W-1:0]     hit_pass_q, hit_pass_d;
  logic [STRIDE_W-1:0]   hit_stride_q, hit_stride_d;
  logic [SHARE_W-1:0]    hit_share_q, hit_share_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TABLE_DEPTH-1:0] rsv_q, rsv_d;
  logic [CW-1:0]         ucnt_q, ucnt_d;
  logic [SHARE_W-1:0]    rtot_q, rtot_d;
  logic [SHARE_W-1:0]    total_q;
  logic [STRIDE_W-1:0]   scale_q;
  logic [SHARE_W-1:0]    share_q, share_d;
  logic [STRIDE_W-1:0]   stride_q, stride_d;
  logic                  res_status_q, res_status_d;
  logic [PID_W-1:0]      res_pid_q, res_pid_d;
  logic                  m_valid_q, m_valid_d;
  logic                  out_status_q, out_status_d;
  logic [PID_W-1:0]      out_pid_q, out_pid_d;

  logic                  wa_en, wb_en;
  entry_a_t              wa_data, ra;
  entry_b_t              wb_data, rb;
  logic [IW-1:0]         wr_addr;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [SHARE_W-1:0]    rtot_less;
  logic [SHARE_W:0]      base;
  logic [SHARE_W-1:0]    free_share;
  logic [PASS_W:0]       pass_sum;
  logic                  scan_last;

  ssch_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i    (clk_i),
    .rd_addr_i(scan_cnt_q),
    .wr_addr_i(wr_addr),
    .wa_en_i  (wa_en),
    .wa_data_i(wa_data),
    .wb_en_i  (wb_en),
    .wb_data_i(wb_data),
    .ra_o     (ra),
    .rb_o     (rb)
  );

  ssch_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign scan_last  = (scan_cnt_q == IW'(TABLE_DEPTH - 1));
  assign rtot_less  = (rtot_q >= hit_share_q) ? (rtot_q - hit_share_q) : '0;
  assign base       = rsv_q[hit_idx_q] ? {1'b0, rtot_less} : {1'b0, rtot_q};
  assign free_share = (total_q > rtot_q) ? (total_q - rtot_q) : '0;
  assign pass_sum   = {1'b0, hit_pass_q} + {{(PASS_W + 1 - STRIDE_W){1'b0}}, hit_stride_q};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_SHARE_RST;
      scale_q <= STRIDE_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL_SHARE:  total_q <= cfg_wdata_i[SHARE_W-1:0];
        CFG_STRIDE_SCALE: scale_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    pid_d        = pid_q;
    pct_d        = pct_q;
    scan_cnt_d   = scan_cnt_q;
    chk_v_d      = 1'b0;
    chk_idx_d    = scan_cnt_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_pid_d    = hit_pid_q;
    hit_pass_d   = hit_pass_q;
    hit_stride_d = hit_stride_q;
    hit_share_d  = hit_share_q;
    valid_d      = valid_q;
    rsv_d        = rsv_q;
    ucnt_d       = ucnt_q;
    rtot_d       = rtot_q;
    share_d      = share_q;
    stride_d     = stride_q;
    res_status_d = res_status_q;
    res_pid_d    = res_pid_q;
    m_valid_d    = m_valid_q;
    out_status_d = out_status_q;
    out_pid_d    = out_pid_q;
    wa_en        = 1'b0;
    wb_en        = 1'b0;
    wa_data      = '{pid: hit_pid_q, pass: '0};
    wb_data      = '{stride: '0, share: '0};
    wr_addr      = hit_idx_q;
    div_req      = '{start: 1'b0, num: scale_q, den: DIV_W'(pct_q)};

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    // Check the entry read in the previous cycle
    if (chk_v_q) begin
      case (op_q)
        OP_START: begin
          if (!found_q && !valid_q[chk_idx_q]) begin
            found_d   = 1'b1;
            hit_idx_d = chk_idx_q;
          end
        end
        OP_PICK: begin
          if (valid_q[chk_idx_q] && (!found_q || ra.pass < hit_pass_q)) begin
            found_d      = 1'b1;
            hit_idx_d    = chk_idx_q;
            hit_pid_d    = ra.pid;
            hit_pass_d   = ra.pass;
            hit_stride_d = rb.stride;
          end
        end
        default: begin
          if (!found_q && valid_q[chk_idx_q] && ra.pid == pid_q) begin
            found_d     = 1'b1;
            hit_idx_d   = chk_idx_q;
            hit_pid_d   = ra.pid;
            hit_share_d = rb.share;
          end
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d       = op_e'(s_axis_tdata_i[1:0]);
          pid_d      = s_axis_tdata_i[17:2];
          pct_d      = s_axis_tdata_i[24:18];
          scan_cnt_d = '0;
          found_d    = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        chk_v_d    = 1'b1;
        scan_cnt_d = scan_cnt_q + IW'(1);
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_APPLY;
      ST_APPLY: begin
        res_status_d = ST_FAIL;
        res_pid_d    = '0;
        state_d      = ST_DONE;
        case (op_q)
          OP_START: begin
            if (found_q) begin
              valid_d[hit_idx_q] = 1'b1;
              rsv_d[hit_idx_q]   = 1'b0;
              wa_en   = 1'b1;
              wa_data = '{pid: pid_q, pass: '0};
              wb_en   = 1'b1;
              ucnt_d  = ucnt_q + CW'(1);
              state_d = ST_REB;
            end
          end
          OP_END: begin
            if (found_q) begin
              if (rsv_q[hit_idx_q]) begin
                rtot_d = rtot_less;
              end else if (ucnt_q != '0) begin
                ucnt_d = ucnt_q - CW'(1);
              end
              valid_d[hit_idx_q] = 1'b0;
              rsv_d[hit_idx_q]   = 1'b0;
              wa_en   = 1'b1;
              wb_en   = 1'b1;
              state_d = ST_REB;
            end
          end
          OP_REQUEST: begin
            if (found_q && pct_q <= PERCENT_MAX) begin
              if (pct_q == '0) begin
                if (rsv_q[hit_idx_q]) begin
                  rsv_d[hit_idx_q] = 1'b0;
                  ucnt_d  = ucnt_q + CW'(1);
                  rtot_d  = rtot_less;
                  state_d = ST_REB;
                end
              end else if ((base + {1'b0, pct_q}) <= {1'b0, total_q}) begin
                if (!rsv_q[hit_idx_q] && ucnt_q != '0) begin
                  ucnt_d = ucnt_q - CW'(1);
                end
                rsv_d[hit_idx_q] = 1'b1;
                rtot_d        = SHARE_W'(base + {1'b0, pct_q});
                div_req.start = 1'b1;
                state_d       = ST_W_REQ;
              end
            end
          end
          default: begin
            if (found_q) begin
              wa_en   = 1'b1;
              wa_data = '{pid: hit_pid_q,
                          pass: pass_sum[PASS_W] ? {PASS_W{1'b1}} : pass_sum[PASS_W-1:0]};
              res_status_d = ST_OK;
              res_pid_d    = hit_pid_q;
            end
          end
        endcase
      end
      ST_W_REQ: begin
        if (div_rsp.done) begin
          wb_en   = 1'b1;
          wb_data = '{stride: div_rsp.quot, share: pct_q};
          state_d = ST_REB;
        end
      end
      ST_REB: begin
        scan_cnt_d = '0;
        if (ucnt_q != '0) begin
          div_req = '{start: 1'b1, num: DIV_W'(free_share), den: DIV_W'(ucnt_q)};
          state_d = ST_W_SHR;
        end else begin
          share_d  = '0;
          stride_d = scale_q;
          state_d  = ST_SWEEP;
        end
      end
      ST_W_SHR: begin
        if (div_rsp.done) begin
          share_d = div_rsp.quot[SHARE_W-1:0];
          if (div_rsp.quot == '0) begin
            stride_d = scale_q;
            state_d  = ST_SWEEP;
          end else begin
            div_req = '{start: 1'b1, num: scale_q, den: div_rsp.quot};
            state_d = ST_W_STR;
          end
        end
      end
      ST_W_STR: begin
        if (div_rsp.done) begin
          stride_d = div_rsp.quot;
          state_d  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // Write the new split into every unreserved live entry
        wr_addr    = scan_cnt_q;
        wb_en      = valid_q[scan_cnt_q] && !rsv_q[scan_cnt_q];
        wb_data    = '{stride: stride_q, share: share_q};
        scan_cnt_d = scan_cnt_q + IW'(1);
        if (scan_last) begin
          res_status_d = ST_OK;
          res_pid_d    = '0;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_pid_d    = res_pid_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_v_q   <= 1'b0;
      found_q   <= 1'b0;
      valid_q   <= '0;
      rsv_q     <= '0;
      ucnt_q    <= '0;
      rtot_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_v_q   <= chk_v_d;
      found_q   <= found_d;
      valid_q   <= valid_d;
      rsv_q     <= rsv_d;
      ucnt_q    <= ucnt_d;
      rtot_q    <= rtot_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pid_q        <= pid_d;
    pct_q        <= pct_d;
    scan_cnt_q   <= scan_cnt_d;
    chk_idx_q    <= chk_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_pid_q    <= hit_pid_d;
    hit_pass_q   <= hit_pass_d;
    hit_stride_q <= hit_stride_d;
    hit_share_q  <= hit_share_d;
    share_q      <= share_d;
    stride_q     <= stride_d;
    res_status_q <= res_status_d;
    res_pid_q    <= res_pid_d;
    out_status_q <= out_status_d;
    out_pid_q    <= out_pid_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_pid_q, out_status_q};

  `SSCH_ASSERT_NEXT(a_accept_scan, s_axis_tvalid_i && s_axis_tready_o, state_q == ST_SCAN, "accepted transaction did not start a scan")
  `SSCH_ASSERT_SAME(a_sweep_div_idle, state_q == ST_SWEEP, !div_rsp.busy, "sweep began before the divider finished")
  `SSCH_ASSERT_SAME(a_check_in_scan, chk_v_q, state_q == ST_SCAN || state_q == ST_DRAIN, "entry check outside the scan")

endmodule

FILE: design/ssch_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ssch_pkg for the request and response types.
module ssch_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssch_pkg::div_req_t req_i,
  output ssch_pkg::div_rsp_t rsp_o
);
  import ssch_pkg::*;

  localparam int unsigned SW = $clog2(DIV_W) + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SW-1:0]    step_q, step_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   trial;

  assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = SW'(DIV_W);
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[DIV_W]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q - SW'(1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: design/ssch_table.sv
// Process table storage: id/pass memory and stride/share memory.
// Synchronous write, registered read; depends on ssch_pkg.
module ssch_table #(
  parameter int unsigned TABLE_DEPTH = ssch_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic [IW-1:0]      rd_addr_i,
  input  logic [IW-1:0]      wr_addr_i,
  input  logic               wa_en_i,
  input  ssch_pkg::entry_a_t wa_data_i,
  input  logic               wb_en_i,
  input  ssch_pkg::entry_b_t wb_data_i,
  output ssch_pkg::entry_a_t ra_o,
  output ssch_pkg::entry_b_t rb_o
);
  import ssch_pkg::*;

  entry_a_t mem_a [TABLE_DEPTH];
  entry_b_t mem_b [TABLE_DEPTH];
  entry_a_t ra_q;
  entry_b_t rb_q;

  always_ff @(posedge clk_i) begin
    if (wa_en_i) begin
      mem_a[wr_addr_i] <= wa_data_i;
    end
    ra_q <= mem_a[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wb_en_i) begin
      mem_b[wr_addr_i] <= wb_data_i;
    end
    rb_q <= mem_b[rd_addr_i];
  end

  assign ra_o = ra_q;
  assign rb_o = rb_q;

endmodule

FILE: test/stride_share_scheduler_test.sv
// Self-checking testbench for the stride share scheduler: directed table, then random traffic.
// Depends on ssch_pkg and the stride_share_scheduler top level; predicts every result itself.
`timescale 1ns / 100ps

module stride_share_scheduler_test;
  import ssch_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [63:0] PASS_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  stride_share_scheduler uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state
  logic [6:0]  tot_share, free_sh, res_total;
  logic [15:0] scale;
  logic        e_valid [DEPTH];
  logic        e_resv  [DEPTH];
  logic [15:0] e_pid   [DEPTH];
  logic [63:0] e_pass  [DEPTH];
  logic [15:0] e_stride[DEPTH];
  logic [6:0]  e_share [DEPTH];
  int unsigned unres_cnt;

  typedef struct packed {
    logic        status;
    logic [15:0] pid;
  } sched_res_t;

  sched_res_t  pending_res[$];
  int          fail_cnt = 0;
  int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int          hold_cycles = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  function automatic logic [15:0] stride_for(logic [6:0] sh);
    if (sh == 0) return scale;
    return 16'(scale / sh);
  endfunction

  task automatic rebalance_shares();
    int unsigned s;
    free_sh = (tot_share > res_total) ? tot_share - res_total : 7'd0;
    for (int i = 0; i < DEPTH; i++) begin
      if (e_valid[i] && !e_resv[i]) begin
        s = (unres_cnt != 0) ? free_sh / unres_cnt : 0;
        e_share[i] = 7'(s);
        e_stride[i] = stride_for(e_share[i]);
      end
    end
  endtask

  function automatic int find_slot(logic [15:0] pid);
    for (int i = 0; i < DEPTH; i++)
      if (e_valid[i] && e_pid[i] == pid) return i;
    return -1;
  endfunction

  task automatic sched_reset();
    tot_share = TOTAL_SHARE_RST;
    scale = STRIDE_SCALE_RST;
    for (int i = 0; i < DEPTH; i++) begin
      e_valid[i] = 0; e_resv[i] = 0; e_pid[i] = 0;
      e_pass[i] = 0; e_stride[i] = 0; e_share[i] = 0;
    end
    unres_cnt = 0; res_total = 0; free_sh = TOTAL_SHARE_RST;
  endtask

  task automatic schedule_op(op_e op, logic [15:0] pid, logic [6:0] pct, output sched_res_t r);
    int i, best;
    logic [6:0] base;
    r = '0;
    r.status = ST_FAIL;
    case (op)
      OP_START: begin
        for (i = 0; i < DEPTH; i++) if (!e_valid[i]) break;
        if (i < DEPTH) begin
          e_valid[i] = 1; e_pid[i] = pid; e_pass[i] = 0; e_resv[i] = 0; e_share[i] = 0;
          unres_cnt++;
          rebalance_shares();
          r.status = ST_OK;
        end
      end
      OP_END: begin
        i = find_slot(pid);
        if (i >= 0) begin
          if (e_resv[i]) res_total = (res_total >= e_share[i]) ? res_total - e_share[i] : 0;
          else if (unres_cnt > 0) unres_cnt--;
          e_valid[i] = 0; e_pass[i] = 0; e_stride[i] = 0; e_share[i] = 0; e_resv[i] = 0;
          rebalance_shares();
          r.status = ST_OK;
        end
      end
      OP_REQUEST: begin
        i = find_slot(pid);
        if (pct <= PERCENT_MAX && i >= 0) begin
          if (pct == 0) begin
            if (e_resv[i]) begin
              e_resv[i] = 0; unres_cnt++;
              res_total = (res_total >= e_share[i]) ? res_total - e_share[i] : 0;
              rebalance_shares();
              r.status = ST_OK;
            end
          end else begin
            base = res_total;
            if (e_resv[i]) base = (base >= e_share[i]) ? base - e_share[i] : 0;
            if (int'(base) + int'(pct) <= int'(tot_share)) begin
              if (!e_resv[i] && unres_cnt > 0) unres_cnt--;
              e_resv[i] = 1; e_share[i] = pct; e_stride[i] = stride_for(pct);
              res_total = base + pct;
              rebalance_shares();
              r.status = ST_OK;
            end
          end
        end
      end
      default: begin
        best = -1;
        for (i = 0; i < DEPTH; i++)
          if (e_valid[i] && (best < 0 || e_pass[i] < e_pass[best])) best = i;
        if (best >= 0) begin
          if (e_pass[best] > PASS_TOP - 64'(e_stride[best])) e_pass[best] = PASS_TOP;
          else e_pass[best] += e_stride[best];
          r.pid = e_pid[best];
          r.status = ST_OK;
        end
      end
    endcase
  endtask

  // Send one transaction; typed=1 means the row carries its own expectation.
  // Valid stays high after acceptance until the next transaction or an idle cycle.
  task automatic send_op(op_e op, logic [15:0] pid, logic [6:0] pct,
                         bit typed = 0, sched_res_t want = '0);
    sched_res_t r;
    schedule_op(op, pid, pct, r);
    if (typed && r != want) begin
      $error("directed row: model gives status %0d pid %0d, row says %0d %0d",
             r.status, r.pid, want.status, want.pid);
      fail_cnt++;
    end
    while ((idle_mode == 1 || idle_mode == 3) &&
           $urandom_range(99) < ((idle_mode == 3) ? 29 : 69)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i <= {7'd0, pct, pid, op};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_res.push_back(typed ? want : r);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_TOTAL_SHARE) tot_share = val[6:0];
    else scale = val;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Receiver: random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 600;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_mode >= 2)
      m_axis_tready_i <= ($urandom_range(99) >= ((idle_mode == 3) ? 29 : 69));
    else m_axis_tready_i <= 1'b1;
  end

  // Result checker
  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[0], m_axis_tdata_o[16:1]};
      if (pending_res.size() == 0) begin
        $error("unexpected result status %0d pid %0d", got.status, got.pid);
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.pid !== want.pid) begin
          $error("chosen_pid: expected %0d, actual %0d", want.pid, got.pid);
          fail_cnt++;
        end
      end
    end
  end

  typedef struct {
    op_e        op;
    logic [15:0] pid;
    logic [6:0]  pct;
    bit          typed;
    sched_res_t  want;
  } dir_row_t;

  localparam sched_res_t R_OK = '{status: ST_OK, pid: 16'd0};
  localparam sched_res_t R_NG = '{status: ST_FAIL, pid: 16'd0};

  dir_row_t dir_rows[] = '{
    '{OP_PICK,    16'd0,     7'd0,   1, R_NG},   // empty table
    '{OP_END,     16'd5,     7'd0,   1, R_NG},   // not present
    '{OP_REQUEST, 16'd5,     7'd10,  1, R_NG},   // not present
    '{OP_START,   16'hFFFF,  7'd127, 1, R_OK},
    '{OP_START,   16'd0,     7'd0,   1, R_OK},
    '{OP_START,   16'hFFFF,  7'd0,   1, R_OK},   // duplicate id
    '{OP_PICK,    16'd0,     7'd0,   0, R_OK},
    '{OP_PICK,    16'd0,     7'd0,   0, R_OK},
    '{OP_REQUEST, 16'hFFFF,  7'd101, 1, R_NG},   // bad percent
    '{OP_REQUEST, 16'hFFFF,  7'd127, 1, R_NG},
    '{OP_REQUEST, 16'd0,     7'd0,   1, R_NG},   // cancel without reservation
    '{OP_REQUEST, 16'hFFFF,  7'd100, 0, R_OK},
    '{OP_REQUEST, 16'd0,     7'd1,   1, R_NG},   // over budget
    '{OP_PICK,    16'd0,     7'd0,   0, R_OK},
    '{OP_REQUEST, 16'hFFFF,  7'd0,   0, R_OK},
    '{OP_REQUEST, 16'hFFFF,  7'd60,  0, R_OK},
    '{OP_REQUEST, 16'hFFFF,  7'd40,  0, R_OK},   // re-reserve
    '{OP_PICK,    16'd0,     7'd0,   0, R_OK},
    '{OP_END,     16'hFFFF,  7'd0,   0, R_OK},
    '{OP_PICK,    16'd0,     7'd0,   0, R_OK},
    '{OP_END,     16'hFFFF,  7'd0,   0, R_OK},
    '{OP_END,     16'd0,     7'd0,   0, R_OK},
    '{OP_PICK,    16'd0,     7'd0,   1, R_NG}
  };

  task automatic random_op();
    int k;
    logic [15:0] pid;
    k = $urandom_range(99);
    pid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    if (k < 25) send_op(OP_START, pid, 7'($urandom));
    else if (k < 38) send_op(OP_END, pid, 7'($urandom));
    else if (k < 58)
      send_op(OP_REQUEST, pid, ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(40)));
    else send_op(OP_PICK, 16'($urandom), 7'($urandom));
  endtask

  initial begin
    sched_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n])
      send_op(dir_rows[n].op, dir_rows[n].pid, dir_rows[n].pct, dir_rows[n].typed,
              dir_rows[n].want);
    drain_results();

    // Fill the table beyond capacity with tiny shares and extreme scales
    write_reg(CFG_TOTAL_SHARE, 16'd1);
    write_reg(CFG_STRIDE_SCALE, 16'hFFFF);
    for (int n = 0; n < 18; n++) send_op(OP_START, 16'(n + 1), 7'd0);
    for (int n = 0; n < 20; n++) send_op(OP_PICK, 16'd0, 7'd0);
    for (int n = 0; n < 16; n++) send_op(OP_END, 16'(n + 1), 7'd0);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      idle_mode = phase % 4;
      case (phase)
        0: begin write_reg(CFG_TOTAL_SHARE, 16'd100); write_reg(CFG_STRIDE_SCALE, 16'd1); end
        1: begin write_reg(CFG_TOTAL_SHARE, 16'd50);  write_reg(CFG_STRIDE_SCALE, 16'd10000); end
        2: begin write_reg(CFG_TOTAL_SHARE, 16'($urandom_range(1, 100)));
                 write_reg(CFG_STRIDE_SCALE, 16'($urandom_range(1, 65535))); end
        3: begin write_reg(CFG_TOTAL_SHARE, 16'd7);   write_reg(CFG_STRIDE_SCALE, 16'd3); end
        default: begin write_reg(CFG_TOTAL_SHARE, 16'd100);
                       write_reg(CFG_STRIDE_SCALE, 16'd65535); end
      endcase
      if (phase == 4) hold_go = 1'b1;   // long receiver hold-off
      for (int n = 0; n < 100; n++) random_op();
      drain_results();
    end

    if (fail_cnt == 0) $display("stride_share_scheduler_test: PASS");
    else $display("stride_share_scheduler_test: FAIL");
    $finish;
  end

  initial begin
    #3000000;
    $display("stride_share_scheduler_test: FAIL");
    $finish;
  end

endmodule
